// File: design/sc2x_pkg.sv
// Shared constants and types of the Scale2x pixel upscaler
`default_nettype none

package sc2x_pkg;

    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [APB_ADDR_W-1:0] ADDR_WIDTH  = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_HEIGHT = 3'd4;

    // pixel slots of one queued item
    localparam int NUM_SLOTS = 7;
    localparam int SLOT_P    = 6;
    localparam int SLOT_E    = 5;
    localparam int SLOT_B2   = 4;
    localparam int SLOT_F    = 3;
    localparam int SLOT_W0   = 2;
    localparam int SLOT_W1   = 1;
    localparam int SLOT_W2   = 0;

    typedef enum logic [2:0] {
        BLK_UPPER  = 3'b001,
        BLK_LEFT   = 3'b010,
        BLK_CORNER = 3'b100
    } blk_kind_t;

    typedef struct packed {
        logic                restart;
        logic [HEIGHT_W-1:0] height;
        logic [WIDTH_W-1:0]  width;
    } frame_cfg_t;

    typedef struct packed {
        logic             has_up;
        logic             has_two;
        logic             has_left;
        logic             has_left2;
        logic             has_right;
        logic             last_row;
        logic             last_col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } item_tag_t;

endpackage

`default_nettype wire

// File: design/sc2x_ifs.sv
// Stream interfaces for source pixels and result blocks
`default_nettype none

interface sc2x_pix_if #(parameter int PIXEL_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sc2x_blk_if #(parameter int PIXEL_BITS = 32);
    logic                        valid;
    logic                        ready;
    logic [sc2x_pkg::ROW_W-1:0]  src_row;
    logic [sc2x_pkg::COL_W-1:0]  src_col;
    logic [PIXEL_BITS-1:0]       top_left;
    logic [PIXEL_BITS-1:0]       top_right;
    logic [PIXEL_BITS-1:0]       bottom_left;
    logic [PIXEL_BITS-1:0]       bottom_right;
    logic                        last_of_item;
    logic                        frame_done;

    modport source (output valid, output src_row, output src_col, output top_left,
                    output top_right, output bottom_left, output bottom_right,
                    output last_of_item, output frame_done, input ready);
    modport sink   (input valid, input src_row, input src_col, input top_left,
                    input top_right, input bottom_left, input bottom_right,
                    input last_of_item, input frame_done, output ready);
endinterface

`default_nettype wire

// File: design/scale2x_pixel_upscaler.sv
// Top level of the Scale2x 2x pixel-art upscaler
//
//   channel   direction  transfer                     payload
//   pix_in    in         valid & ready                pixel
//   blk_out   out        valid & ready                src_row, src_col, four pixels,
//                                                     last_of_item, frame_done
//   APB       in/out     psel & penable & pwrite      frame_width @0, frame_height @4
//
// One source pixel per clock is taken while each pixel yields at most one block and
// blk_out is ready. On the last source row the back end emits up to three blocks per
// pixel, one per clock while blk_out is ready; the four-entry queue absorbs these
// and input stalls once it is full. Each block leaves from the back-end result register.
// The line store needs no clearing pass: rows are read only after being written.
// A write to frame_width or frame_height restarts the frame at row 0, column 0.
`default_nettype none

module scale2x_pixel_upscaler #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sc2x_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sc2x_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sc2x_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    sc2x_pix_if.sink                             pix_in,
    sc2x_blk_if.source                           blk_out
);
    import sc2x_pkg::*;

    localparam int DW = $bits(item_tag_t) + NUM_SLOTS * PIXEL_BITS;

    frame_cfg_t                       cfg;
    logic                             f_valid;
    logic                             f_ready;
    item_tag_t                        f_tag;
    logic [NUM_SLOTS*PIXEL_BITS-1:0]  f_data;
    logic                             b_valid;
    logic                             b_ready;
    logic [DW-1:0]                    b_word;
    item_tag_t                        b_tag;

    sc2x_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sc2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pix_in  (pix_in),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_tag   (f_tag),
        .q_data  (f_data)
    );

    sc2x_fifo #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_tag, f_data}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_word)
    );

    assign b_tag = b_word[DW-1:NUM_SLOTS*PIXEL_BITS];

    sc2x_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_tag   (b_tag),
        .q_data  (b_word[NUM_SLOTS*PIXEL_BITS-1:0]),
        .blk_out (blk_out)
    );

endmodule

`default_nettype wire

// File: design/sc2x_cfg.sv
// APB register bank: frame width and height
`default_nettype none

module sc2x_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sc2x_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sc2x_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sc2x_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output sc2x_pkg::frame_cfg_t                 cfg
);
    import sc2x_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                wr_en;
    logic                wr_hit;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr)
            ADDR_WIDTH:  wr_hit = wr_en;
            ADDR_HEIGHT: wr_hit = wr_en;
            default:     wr_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_WIDTH:  prdata = APB_DATA_W'(width_reg);
            ADDR_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(320);
            height_reg <= HEIGHT_W'(240);
        end
        else if (wr_en)
        begin
            if (paddr == ADDR_WIDTH)
            begin
                width_reg <= pwdata[WIDTH_W-1:0];
            end
            if (paddr == ADDR_HEIGHT)
            begin
                height_reg <= pwdata[HEIGHT_W-1:0];
            end
        end
    end

    assign cfg.restart = wr_hit;
    assign cfg.width   = width_reg;
    assign cfg.height  = height_reg;

endmodule

`default_nettype wire

// File: design/sc2x_front.sv
// Front end: position tracking, line store and neighbour gathering
`default_nettype none

module sc2x_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sc2x_pkg::frame_cfg_t     cfg,
    sc2x_pix_if.sink                      pix_in,
    output logic                          q_valid,
    input  wire logic                     q_ready,
    output sc2x_pkg::item_tag_t           q_tag,
    output logic [sc2x_pkg::NUM_SLOTS*PIXEL_BITS-1:0] q_data
);
    import sc2x_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int PB = PIXEL_BITS;

    logic [EW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic                last_col;
    logic                last_row;
    logic                accept;

    // line store entry: upper half is the row above, lower half two rows above
    logic [2*PB-1:0]     mem [MAX_WIDTH];
    logic [2*PB-1:0]     rd_q;
    logic [2*PB-1:0]     cur_q;
    logic [2*PB-1:0]     entry;
    logic [2*PB-1:0]     wr_data;
    logic [CW-1:0]       rd_addr;

    logic                a_valid_reg;
    logic [PB-1:0]       a_pix_reg;
    item_tag_t           a_tag_reg;
    item_tag_t           tag_next;
    logic                a_blocks;
    logic                a_leave;

    logic [PB-1:0]       w0_reg;
    logic [PB-1:0]       w1_reg;
    logic [PB-1:0]       w2_reg;

    always_comb
    begin
        if (cfg.width == '0)
        begin
            eff_w = EW'(1);
        end
        else if (32'(cfg.width) > 32'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(cfg.width);
        end

        if (cfg.height == '0)
        begin
            eff_h = HEIGHT_W'(1);
        end
        else if (32'(cfg.height) > 32'(MAX_HEIGHT))
        begin
            eff_h = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = cfg.height;
        end
    end

    assign last_col = (32'(col_reg) + 32'd1) == 32'(eff_w);
    assign last_row = ({1'b0, row_reg} + HEIGHT_W'(1)) == eff_h;

    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
    end

    assign a_blocks = a_tag_reg.has_up
                   || (a_tag_reg.last_row && a_tag_reg.has_left)
                   || (a_tag_reg.last_row && a_tag_reg.last_col);
    assign a_leave  = a_valid_reg && (!a_blocks || q_ready);
    assign q_valid  = a_valid_reg && a_blocks;

    assign pix_in.ready = !a_valid_reg || a_leave;
    assign accept       = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // entry of the current column: still in the read register while the
    // previous pixel leaves in the same cycle
    assign entry   = a_valid_reg ? rd_q : cur_q;
    assign wr_data = {pix_in.pixel, entry[2*PB-1:PB]};
    assign rd_addr = last_col ? '0 : col_reg + CW'(1);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[col_reg] <= wr_data;
            rd_q         <= (rd_addr == col_reg) ? wr_data : mem[rd_addr];
        end
    end

    always_comb
    begin
        tag_next.has_up    = row_reg != '0;
        tag_next.has_two   = row_reg > ROW_W'(1);
        tag_next.has_left  = col_reg != '0;
        tag_next.has_left2 = 32'(col_reg) >= 32'd2;
        tag_next.has_right = !last_col;
        tag_next.last_row  = last_row;
        tag_next.last_col  = last_col;
        tag_next.row       = row_reg;
        tag_next.col       = COL_W'(col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_leave)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg <= pix_in.pixel;
            a_tag_reg <= tag_next;
        end
        if (a_leave)
        begin
            cur_q <= rd_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg <= '0;
            w1_reg <= '0;
            w2_reg <= '0;
        end
        else if (a_leave)
        begin
            if (a_tag_reg.has_up)
            begin
                w0_reg <= cur_q[2*PB-1:PB];
            end
            w1_reg <= a_pix_reg;
            w2_reg <= w1_reg;
        end
    end

    assign q_tag = a_tag_reg;

    always_comb
    begin
        q_data                  = '0;
        q_data[SLOT_P*PB +: PB]  = a_pix_reg;
        q_data[SLOT_E*PB +: PB]  = cur_q[2*PB-1:PB];
        q_data[SLOT_B2*PB +: PB] = cur_q[PB-1:0];
        q_data[SLOT_F*PB +: PB]  = rd_q[2*PB-1:PB];
        q_data[SLOT_W0*PB +: PB] = w0_reg;
        q_data[SLOT_W1*PB +: PB] = w1_reg;
        q_data[SLOT_W2*PB +: PB] = w2_reg;
    end

endmodule

`default_nettype wire

// File: design/sc2x_fifo.sv
// Short register queue between front and back ends
`default_nettype none

module sc2x_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slots [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != (AW + 1)'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slots[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: design/sc2x_back.sv
// Back end: Scale2x block rules and result register
`default_nettype none

module sc2x_back #(
    parameter int PIXEL_BITS = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    output logic                          q_ready,
    input  wire sc2x_pkg::item_tag_t      q_tag,
    input  wire logic [sc2x_pkg::NUM_SLOTS*PIXEL_BITS-1:0] q_data,
    sc2x_blk_if.source                    blk_out
);
    import sc2x_pkg::*;

    localparam int PB = PIXEL_BITS;

    logic [PB-1:0]    p;
    logic [PB-1:0]    e_up;
    logic [PB-1:0]    b2;
    logic [PB-1:0]    f_up;
    logic [PB-1:0]    w0;
    logic [PB-1:0]    w1;
    logic [PB-1:0]    w2;

    logic [2:0]       pend;
    logic [2:0]       done_reg;
    logic [2:0]       remain;
    blk_kind_t        sel;
    logic             is_last;
    logic             load;

    logic [PB-1:0]    nb_b;
    logic [PB-1:0]    nb_d;
    logic [PB-1:0]    nb_e;
    logic [PB-1:0]    nb_f;
    logic [PB-1:0]    nb_h;
    logic [ROW_W-1:0] row_sel;
    logic [COL_W-1:0] col_sel;
    logic [PB-1:0]    tl;
    logic [PB-1:0]    tr;
    logic [PB-1:0]    bl;
    logic [PB-1:0]    br;

    logic             out_valid_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [PB-1:0]    tl_reg;
    logic [PB-1:0]    tr_reg;
    logic [PB-1:0]    bl_reg;
    logic [PB-1:0]    br_reg;
    logic             last_reg;
    logic             done_flag_reg;

    assign p    = q_data[SLOT_P*PB +: PB];
    assign e_up = q_data[SLOT_E*PB +: PB];
    assign b2   = q_data[SLOT_B2*PB +: PB];
    assign f_up = q_data[SLOT_F*PB +: PB];
    assign w0   = q_data[SLOT_W0*PB +: PB];
    assign w1   = q_data[SLOT_W1*PB +: PB];
    assign w2   = q_data[SLOT_W2*PB +: PB];

    assign pend   = {q_tag.last_row && q_tag.last_col,
                     q_tag.last_row && q_tag.has_left,
                     q_tag.has_up};
    assign remain = pend & ~done_reg;

    always_comb
    begin
        if (remain[0])
        begin
            sel = BLK_UPPER;
        end
        else if (remain[1])
        begin
            sel = BLK_LEFT;
        end
        else
        begin
            sel = BLK_CORNER;
        end
    end

    assign is_last = (remain & ~3'(sel)) == 3'b000;

    // pick the neighbours of the block in hand
    always_comb
    begin
        unique case (sel)
            BLK_UPPER:
            begin
                nb_e    = e_up;
                nb_b    = q_tag.has_two ? b2 : e_up;
                nb_d    = q_tag.has_left ? w0 : e_up;
                nb_f    = q_tag.has_right ? f_up : e_up;
                nb_h    = p;
                row_sel = q_tag.row - ROW_W'(1);
                col_sel = q_tag.col;
            end
            BLK_LEFT:
            begin
                nb_e    = w1;
                nb_b    = q_tag.has_up ? w0 : w1;
                nb_d    = q_tag.has_left2 ? w2 : w1;
                nb_f    = p;
                nb_h    = w1;
                row_sel = q_tag.row;
                col_sel = q_tag.col - COL_W'(1);
            end
            BLK_CORNER:
            begin
                nb_e    = p;
                nb_b    = q_tag.has_up ? e_up : p;
                nb_d    = q_tag.has_left ? w1 : p;
                nb_f    = p;
                nb_h    = p;
                row_sel = q_tag.row;
                col_sel = q_tag.col;
            end
            default:
            begin
                nb_e    = p;
                nb_b    = p;
                nb_d    = p;
                nb_f    = p;
                nb_h    = p;
                row_sel = q_tag.row;
                col_sel = q_tag.col;
            end
        endcase
    end

    always_comb
    begin
        tl = nb_e;
        tr = nb_e;
        bl = nb_e;
        br = nb_e;
        if ((nb_b != nb_h) && (nb_d != nb_f))
        begin
            tl = (nb_d == nb_b) ? nb_d : nb_e;
            tr = (nb_b == nb_f) ? nb_f : nb_e;
            bl = (nb_d == nb_h) ? nb_d : nb_e;
            br = (nb_h == nb_f) ? nb_f : nb_e;
        end
    end

    assign load    = q_valid && (!out_valid_reg || blk_out.ready);
    assign q_ready = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                done_reg      <= is_last ? 3'b000 : (done_reg | 3'(sel));
                out_valid_reg <= 1'b1;
            end
            else if (blk_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg       <= row_sel;
            col_reg       <= col_sel;
            tl_reg        <= tl;
            tr_reg        <= tr;
            bl_reg        <= bl;
            br_reg        <= br;
            last_reg      <= is_last;
            done_flag_reg <= sel == BLK_CORNER;
        end
    end

    assign blk_out.valid        = out_valid_reg;
    assign blk_out.src_row      = row_reg;
    assign blk_out.src_col      = col_reg;
    assign blk_out.top_left     = tl_reg;
    assign blk_out.top_right    = tr_reg;
    assign blk_out.bottom_left  = bl_reg;
    assign blk_out.bottom_right = br_reg;
    assign blk_out.last_of_item = last_reg;
    assign blk_out.frame_done   = done_flag_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for the Scale2x upscaler: predicts 2x2 blocks per source pixel and checks every transfer
`default_nettype none

module tb;
    import sc2x_pkg::*;

    localparam int MAX_WIDTH    = 2048;
    localparam int PIXEL_BITS   = 32;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 500000;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pixel_t           tl;
        pixel_t           tr;
        pixel_t           bl;
        pixel_t           br;
        logic             is_last;
        logic             is_done;
    } block_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    sc2x_pix_if #(.PIXEL_BITS(PIXEL_BITS)) pix_if ();
    sc2x_blk_if #(.PIXEL_BITS(PIXEL_BITS)) blk_if ();

    scale2x_pixel_upscaler #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_if),
        .blk_out (blk_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scaler state as the block should hold it
    pixel_t               upper_row [MAX_WIDTH];
    pixel_t               older_row [MAX_WIDTH];
    pixel_t               prev_centre = '0;
    pixel_t               behind1 = '0;
    pixel_t               behind2 = '0;
    int                   row_pos = 0;
    int                   col_pos = 0;
    logic [WIDTH_W-1:0]   width_reg = 12'd320;
    logic [HEIGHT_W-1:0]  height_reg = 13'd240;

    block_t expected_blocks [$];
    int     mismatches = 0;
    int     cycles = 0;
    int     send_idle_pct;
    int     recv_idle_pct;
    pixel_t palette [4];
    int     palette_size = 2;

    function automatic int active_width();
        int w;
        w = int'(width_reg);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = int'(height_reg);
        if (h == 0) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic block_t expand_block(input int row, input int col, input pixel_t b,
                                            input pixel_t d, input pixel_t e, input pixel_t f,
                                            input pixel_t h, input logic done);
        block_t blk;
        blk.row = ROW_W'(row);
        blk.col = COL_W'(col);
        blk.tl = e;
        blk.tr = e;
        blk.bl = e;
        blk.br = e;
        if (b != h && d != f)
        begin
            blk.tl = (d == b) ? d : e;
            blk.tr = (b == f) ? f : e;
            blk.bl = (d == h) ? d : e;
            blk.br = (h == f) ? f : e;
        end
        blk.is_last = 1'b0;
        blk.is_done = done;
        return blk;
    endfunction

    task automatic predict_blocks(input pixel_t p);
        block_t blocks [3];
        int     n;
        int     w;
        int     hgt;
        int     r;
        int     c;
        pixel_t b;
        pixel_t d;
        pixel_t e;
        pixel_t f;
        n = 0;
        w = active_width();
        hgt = active_height();
        r = row_pos;
        c = col_pos;
        if (r >= hgt || c >= w)
        begin
            r = 0;
            c = 0;
        end
        if (r >= 1)
        begin
            e = upper_row[c];
            b = (r >= 2) ? older_row[c] : e;
            d = (c > 0) ? prev_centre : e;
            f = (c + 1 < w) ? upper_row[c + 1] : e;
            blocks[n] = expand_block(r - 1, c, b, d, e, f, p, 1'b0);
            n++;
            prev_centre = e;
        end
        older_row[c] = upper_row[c];
        upper_row[c] = p;
        if (r == hgt - 1)
        begin
            if (c >= 1)
            begin
                e = behind1;
                d = (c >= 2) ? behind2 : e;
                b = (r >= 1) ? older_row[c - 1] : e;
                blocks[n] = expand_block(r, c - 1, b, d, e, p, e, 1'b0);
                n++;
            end
            if (c == w - 1)
            begin
                d = (c >= 1) ? behind1 : p;
                b = (r >= 1) ? older_row[c] : p;
                blocks[n] = expand_block(r, c, b, d, p, p, p, 1'b1);
                n++;
            end
        end
        behind2 = behind1;
        behind1 = p;
        if (n > 0)
            blocks[n - 1].is_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_blocks.push_back(blocks[i]);
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= hgt) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_blocks
        block_t want;
        if (rst_n && blk_if.valid && blk_if.ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: block row %0d col %0d expected none", $time,
                         blk_if.src_row, blk_if.src_col);
                mismatches++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                check_field("src_row", 32'(want.row), 32'(blk_if.src_row));
                check_field("src_col", 32'(want.col), 32'(blk_if.src_col));
                check_field("top_left", want.tl, blk_if.top_left);
                check_field("top_right", want.tr, blk_if.top_right);
                check_field("bottom_left", want.bl, blk_if.bottom_left);
                check_field("bottom_right", want.br, blk_if.bottom_right);
                check_field("last_of_item", 32'(want.is_last), 32'(blk_if.last_of_item));
                check_field("frame_done", 32'(want.is_done), 32'(blk_if.frame_done));
            end
        end
    end

    always @(posedge clk)
        blk_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_pixel(input pixel_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            pix_if.pixel <= $urandom;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= p;
        do @(posedge clk); while (!pix_if.ready);
        predict_blocks(p);
    endtask

    // drop valid and wait out every outstanding block
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_WIDTH)
            width_reg = data[WIDTH_W-1:0];
        else if (addr == ADDR_HEIGHT)
            height_reg = data[HEIGHT_W-1:0];
        row_pos = 0;
        col_pos = 0;
        @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        settle();
        write_reg(ADDR_WIDTH, APB_DATA_W'(w));
        write_reg(ADDR_HEIGHT, APB_DATA_W'(h));
    endtask

    task automatic refresh_palette();
        palette_size = $urandom_range(2, 4);
        for (int i = 0; i < 4; i++)
            palette[i] = $urandom;
        if ($urandom_range(3) == 0) palette[0] = '0;
        if ($urandom_range(3) == 0) palette[1] = '1;
    endtask

    function automatic pixel_t pick_pixel();
        if ($urandom_range(9) < 7)
            return palette[$urandom_range(palette_size - 1)];
        return $urandom;
    endfunction

    task automatic send_frames(input int count);
        for (int k = 0; k < count; k++)
            send_pixel(pick_pixel());
    endtask

    // reset dimensions: a short run stays inside the first row and gives nothing
    task automatic test_reset_dimensions();
        refresh_palette();
        send_frames(12);
    endtask

    task automatic test_directed_patterns();
        pixel_t shape_a [9];
        pixel_t shape_b [9];
        pixel_t x;
        pixel_t y;
        pixel_t z;
        x = '0;
        y = '1;
        z = 32'ha5a5_a5a5;
        shape_a = '{x, x, y, x, z, y, z, z, y};
        shape_b = '{x, y, x, z, 32'h5a5a_5a5a, y, x, z, x};
        set_frame(0, 0);
        send_pixel('1);
        set_frame(2, 1);
        send_pixel('0);
        send_pixel('1);
        set_frame(3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel(shape_a[i]);
        for (int i = 0; i < 9; i++)
            send_pixel(shape_b[i]);
    endtask

    task automatic test_restart_mid_frame();
        refresh_palette();
        set_frame(5, 4);
        send_frames(12);
        settle();
        write_reg(ADDR_HEIGHT, 4);
        send_frames(20);
        send_frames(7);
        settle();
        write_reg(ADDR_WIDTH, 5);
        send_frames(40);
    endtask

    task automatic run_random_frames(input int budget);
        int sent;
        int w;
        int h;
        int total;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(7) == 0)
            begin
                w = $urandom_range(9, 40);
                h = $urandom_range(1, 3);
                total = w * h;
            end
            else
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 6);
                total = w * h * $urandom_range(1, 2);
            end
            if ($urandom_range(5) == 0)
                total = $urandom_range(1, w * h);
            set_frame(w, h);
            refresh_palette();
            send_frames(total);
            sent += total;
        end
    endtask

    // widest single row, clamped width and clamped height, each on a short run
    task automatic test_size_extremes();
        refresh_palette();
        set_frame(MAX_WIDTH, 1);
        send_frames(8);
        set_frame(4095, 2);
        send_frames(8);
        set_frame(1, 8191);
        send_frames(8);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        blk_if.ready = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 82;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_dimensions();
        test_directed_patterns();
        run_random_frames(30);

        send_idle_pct = 82;
        recv_idle_pct = 27;
        test_restart_mid_frame();
        run_random_frames(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_frames(30);
        test_size_extremes();

        settle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
